[hdl/mhr_pkg.sv]
// Shared types, constants and register map for the masked HSL recolor pipeline.
package mhr_pkg;

	localparam int unsigned CfgW   = 9;
	localparam int unsigned SumW   = 9;	// max + min, 0..510
	localparam int unsigned NumW   = 17;	// n1, n2 over 510*256
	localparam int unsigned AccW   = 23;	// channel numerator over 510*256*60
	localparam int unsigned AddrW  = 3;
	localparam int unsigned DataW  = 32;

	localparam logic [CfgW-1:0] HUE_MAX = 9'd359;
	localparam logic [CfgW-1:0] SAT_ONE = 9'd256;

	// register indexes, taken from paddr[2]
	localparam logic REG_HUE = 1'b0;
	localparam logic REG_SAT = 1'b1;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic [7:0] pixel_alpha;
		logic [7:0] mask_byte;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} rec_t;

	// pass-through part of a word travelling alongside the arithmetic
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       recolor;
	} side_t;

endpackage

[hdl/masked_hsl_recolor.sv]
// Top level: register file, valid/stall control and four-stage recolor pipeline.
// Each accepted word passes stages s1 to s4 before rec_valid; throughput one word per cycle unless rec_stall holds it.
// A stage with no valid word fills even while the output is stalled.
// pix_stall rises only when every stage holds a word and rec_stall is high.
// arst_n clears the valid bits and both registers (hue 0, saturation 0).
module masked_hsl_recolor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mhr_pkg::AddrW-1:0] paddr,
	input  logic [mhr_pkg::DataW-1:0] pwdata,
	output logic [mhr_pkg::DataW-1:0] prdata,
	output logic                      pready,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  mhr_pkg::pix_t             pix,
	output logic                      rec_valid,
	input  logic                      rec_stall,
	output mhr_pkg::rec_t             rec
);
	import mhr_pkg::*;

	logic [CfgW-1:0] hue_q;
	logic [CfgW-1:0] sat_q;
	logic [CfgW-1:0] wval;
	logic [CfgW-1:0] hue_r;
	logic [CfgW-1:0] hue_b;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;

	side_t side_s1, side_s2, side_s3;
	rec_t  rec_s4;

	logic [SumW-1:0] sum_s1;
	logic [NumW-1:0] n1_s2;
	logic [NumW-1:0] n2_s2;
	logic [7:0]      red_c, green_c, blue_c;

	// configuration
	assign pready = 1'b1;
	assign wval   = pwdata[CfgW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q <= '0;
			sat_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_HUE: hue_q <= (wval > HUE_MAX) ? HUE_MAX : wval;
				REG_SAT: sat_q <= (wval > SAT_ONE) ? SAT_ONE : wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HUE: prdata = DataW'(hue_q);
			REG_SAT: prdata = DataW'(sat_q);
			default: prdata = '0;
		endcase
	end

	// hue offsets: red +120 (360 kept as is), blue -120
	always_comb begin
		hue_r = hue_q + 9'd120;
		if (hue_r > 9'd360) hue_r = hue_r - 9'd360;
		hue_b = (hue_q >= 9'd120) ? (hue_q - 9'd120) : (hue_q + 9'd240);
	end

	// stage enables: a stage moves when empty or when the next one moves
	assign en4       = !v4_s4 || !rec_stall;
	assign en3       = !v3_s3 || en4;
	assign en2       = !v2_s2 || en3;
	assign en1       = !v1_s1 || en2;
	assign pix_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= pix_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1.red     <= pix.pixel_red;
			side_s1.green   <= pix.pixel_green;
			side_s1.blue    <= pix.pixel_blue;
			side_s1.alpha   <= pix.pixel_alpha;
			side_s1.recolor <= (pix.mask_byte != 8'd0);
		end
		if (en2) side_s2 <= side_s1;
		if (en3) side_s3 <= side_s2;
		if (en4) begin
			rec_s4.out_alpha <= side_s3.alpha;
			if (side_s3.recolor) begin
				rec_s4.out_red   <= red_c;
				rec_s4.out_green <= green_c;
				rec_s4.out_blue  <= blue_c;
			end else begin
				rec_s4.out_red   <= side_s3.red;
				rec_s4.out_green <= side_s3.green;
				rec_s4.out_blue  <= side_s3.blue;
			end
		end
	end

	mhr_lum u_lum (
		.clk    (clk),
		.en     (en1),
		.pix    (pix),
		.sum_s1 (sum_s1)
	);

	mhr_level u_level (
		.clk    (clk),
		.en     (en2),
		.sum_s1 (sum_s1),
		.sat    (sat_q),
		.n1_s2  (n1_s2),
		.n2_s2  (n2_s2)
	);

	mhr_chan u_red (
		.clk   (clk),
		.en3   (en3),
		.n1_s2 (n1_s2),
		.n2_s2 (n2_s2),
		.hue   (hue_r),
		.chan  (red_c)
	);

	mhr_chan u_green (
		.clk   (clk),
		.en3   (en3),
		.n1_s2 (n1_s2),
		.n2_s2 (n2_s2),
		.hue   (hue_q),
		.chan  (green_c)
	);

	mhr_chan u_blue (
		.clk   (clk),
		.en3   (en3),
		.n1_s2 (n1_s2),
		.n2_s2 (n2_s2),
		.hue   (hue_b),
		.chan  (blue_c)
	);

	assign rec_valid = v4_s4;
	assign rec       = rec_s4;

endmodule

[hdl/mhr_lum.sv]
// Stage 1: max + min of the colour channels (twice the HSL lightness scaled by 255).
module mhr_lum (
	input  logic               clk,
	input  logic               en,
	input  mhr_pkg::pix_t      pix,
	output logic [mhr_pkg::SumW-1:0] sum_s1
);
	import mhr_pkg::*;

	logic [7:0] mx;
	logic [7:0] mn;

	always_comb begin
		mx = (pix.pixel_red > pix.pixel_green) ? pix.pixel_red : pix.pixel_green;
		if (pix.pixel_blue > mx) mx = pix.pixel_blue;
		mn = (pix.pixel_red < pix.pixel_green) ? pix.pixel_red : pix.pixel_green;
		if (pix.pixel_blue < mn) mn = pix.pixel_blue;
	end

	always_ff @(posedge clk) begin
		if (en) sum_s1 <= {1'b0, mx} + {1'b0, mn};
	end

endmodule

[hdl/mhr_level.sv]
// Stage 2: the two HSL levels v1, v2 as numerators over 510*256.
module mhr_level (
	input  logic                     clk,
	input  logic                     en,
	input  logic [mhr_pkg::SumW-1:0] sum_s1,
	input  logic [mhr_pkg::CfgW-1:0] sat,
	output logic [mhr_pkg::NumW-1:0] n1_s2,
	output logic [mhr_pkg::NumW-1:0] n2_s2
);
	import mhr_pkg::*;

	logic             dark;
	logic [9:0]       coef;
	logic [18:0]      prod;
	logic [18:0]      offs;
	logic [18:0]      n2;
	logic [18:0]      n1;

	// l < 0.5: v2 = l*(1+s); else v2 = l + s - l*s
	always_comb begin
		dark = (sum_s1 < 9'd255);
		coef = dark ? ({1'b0, SAT_ONE} + {1'b0, sat}) : ({1'b0, SAT_ONE} - {1'b0, sat});
		prod = 19'(sum_s1 * coef);
		offs = dark ? 19'd0 : ({1'b0, sat, 9'd0} - {9'd0, sat, 1'b0});
		n2   = prod + offs;
		n1   = {1'b0, sum_s1, 9'd0} - n2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s2 <= n1[NumW-1:0];
			n2_s2 <= n2[NumW-1:0];
		end
	end

endmodule

[hdl/mhr_chan.sv]
// Stages 3 and 4 for one channel: piecewise hue ramp, then scale to 8 bits.
module mhr_chan (
	input  logic                     clk,
	input  logic                     en3,
	input  logic [mhr_pkg::NumW-1:0] n1_s2,
	input  logic [mhr_pkg::NumW-1:0] n2_s2,
	input  logic [mhr_pkg::CfgW-1:0] hue,
	output logic [7:0]               chan
);
	import mhr_pkg::*;

	logic [NumW-1:0] base;
	logic [NumW-1:0] diff;
	logic [5:0]      wgt;
	logic [AccW-1:0] num;
	logic [AccW-1:0] num_s3;
	logic [12:0]     coarse;
	logic [26:0]     prod;

	always_comb begin
		diff = n2_s2 - n1_s2;
		base = n1_s2;
		wgt  = 6'd0;
		priority if (hue < 9'd60) begin
			wgt = hue[5:0];
		end else if (hue < 9'd180) begin
			base = n2_s2;
		end else if (hue < 9'd240) begin
			wgt = 6'(9'd240 - hue);
		end else begin
			wgt = 6'd0;
		end
		num = AccW'(base * 6'd60) + AccW'(diff * wgt);
	end

	always_ff @(posedge clk) begin
		if (en3) num_s3 <= num;
	end

	// floor(num*255 / (510*256*60)) = floor(floor(num/1024) / 30)
	always_comb begin
		coarse = num_s3[AccW-1:10];
		prod   = coarse * 14'd8739;
		chan   = prod[25:18];
	end

endmodule
